### hdl/dqir_pkg.sv
// shared types and codes for the deque with indexed read
// used by the controller, the datapath and the top level; no dependencies
package dqir_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int DEPTH_DEF      = 64;

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 8;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ_AT    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [VALUE_W-1:0] push_value;
        logic [INDEX_W-1:0] index;
    } req_t;

    typedef struct packed {
        logic [VALUE_W-1:0]  read_value;
        logic [STATUS_W-1:0] status;
        logic [COUNT_W-1:0]  count;
    } rsp_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic execute;
        logic load;
    } cmd_t;

endpackage

### hdl/dqir_datapath.sv
// datapath: item register, ring pointers, element store and result register
// depends on dqir_pkg for the word types, op and status codes
module dqir_datapath #(
    parameter int DATA_WIDTH = dqir_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH      = dqir_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  dqir_pkg::cmd_t cmd,
    input  dqir_pkg::req_t req,
    output dqir_pkg::rsp_t rsp
);

    localparam int PW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SUMW = ((PW > dqir_pkg::INDEX_W) ? PW : dqir_pkg::INDEX_W) + 1;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    dqir_pkg::req_t item_reg;
    logic [PW-1:0] front_reg, front_next;
    logic [CW-1:0] count_reg, count_next;

    logic [PW-1:0]         addr;
    logic                  wr_en;
    logic                  rd_hit;
    logic [dqir_pkg::STATUS_W-1:0] status;

    logic [DATA_WIDTH-1:0] rd_data_reg;
    logic                  rd_hit_reg;
    logic [dqir_pkg::STATUS_W-1:0] status_reg;
    logic [CW-1:0]         count_hold_reg;
    dqir_pkg::rsp_t        rsp_reg;

    // reduce a sum below twice the depth into a ring position
    function automatic logic [PW-1:0] wrap(input logic [SUMW-1:0] s);
        logic [SUMW-1:0] d;
        d = SUMW'(DEPTH);
        if (s >= d)
            return PW'(s - d);
        else
            return PW'(s);
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= req;
    end

    always_comb
    begin
        addr       = front_reg;
        wr_en      = 1'b0;
        rd_hit     = 1'b0;
        status     = dqir_pkg::ST_OK;
        front_next = front_reg;
        count_next = count_reg;
        case (item_reg.operation)
            dqir_pkg::OP_PUSH_BACK:
            begin
                if (count_reg == CW'(DEPTH))
                    status = dqir_pkg::ST_FULL;
                else
                begin
                    addr       = wrap(SUMW'(front_reg) + SUMW'(count_reg));
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            dqir_pkg::OP_PUSH_FRONT:
            begin
                if (count_reg == CW'(DEPTH))
                    status = dqir_pkg::ST_FULL;
                else
                begin
                    front_next = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - 1'b1;
                    addr       = front_next;
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            dqir_pkg::OP_POP_BACK:
            begin
                if (count_reg == '0)
                    status = dqir_pkg::ST_EMPTY;
                else
                begin
                    addr       = wrap(SUMW'(front_reg) + SUMW'(count_reg) - 1'b1);
                    rd_hit     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
            end
            dqir_pkg::OP_POP_FRONT:
            begin
                if (count_reg == '0)
                    status = dqir_pkg::ST_EMPTY;
                else
                begin
                    addr       = front_reg;
                    rd_hit     = 1'b1;
                    front_next = wrap(SUMW'(front_reg) + 1'b1);
                    count_next = count_reg - 1'b1;
                end
            end
            dqir_pkg::OP_READ_AT:
            begin
                if (SUMW'(item_reg.index) >= SUMW'(count_reg))
                    status = dqir_pkg::ST_EMPTY;
                else
                begin
                    addr   = wrap(SUMW'(front_reg) + SUMW'(item_reg.index));
                    rd_hit = 1'b1;
                end
            end
            default:
                status = dqir_pkg::ST_EMPTY;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    // element store, one access per item
    always_ff @(posedge clk)
    begin
        if (cmd.execute)
        begin
            if (wr_en)
                mem[addr] <= DATA_WIDTH'(item_reg.push_value);
            rd_data_reg    <= mem[addr];
            rd_hit_reg     <= rd_hit;
            status_reg     <= status;
            count_hold_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rsp_reg.read_value <= rd_hit_reg ? dqir_pkg::VALUE_W'(rd_data_reg) : '0;
            rsp_reg.status     <= status_reg;
            rsp_reg.count      <= dqir_pkg::COUNT_W'(count_hold_reg);
        end
    end

    assign rsp = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("element count beyond depth");

    a_ptr_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(cmd.execute) |-> ($stable(count_reg) && $stable(front_reg)))
        else $error("ring pointers moved without an execute");

endmodule

### hdl/dqir_ctrl.sv
// controller: sequences one word through capture, store access and result load
// depends on dqir_pkg for the command struct
module dqir_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dqir_pkg::cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free  = !out_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = out_valid_reg;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        cmd.load    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = S_LOAD;
            end
            S_LOAD:
            begin
                // wait here until the result register can take the word
                if (out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !rsp_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> (!out_valid_reg || !rsp_stall))
        else $error("result loaded over a waiting word");

    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.load))
        else $error("result valid without a load");

    a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) |=> (cmd.execute && $past(cmd.capture)))
        else $error("accepted word not executed next cycle");

endmodule

### hdl/deque_with_indexed_read_top.sv
// Double-ended queue of DEPTH words of DATA_WIDTH bits in a ring store, with
// push and pop at both ends and a non-destructive read at an index from the
// front. Each request word gives one response word carrying the value read,
// a status (ok, empty or index out of range, full) and the count afterwards.
// Each item passes through capture, one access of the single-port store, then
// the result register load; the next request is taken only once the load is
// done, and the load waits while the response side stalls. The store has no
// reset; only entries written by a push are ever returned.
// depends on dqir_pkg, dqir_ctrl and dqir_datapath
module deque_with_indexed_read_top #(
    parameter int DATA_WIDTH = dqir_pkg::DATA_WIDTH_DEF,
    parameter int DEPTH      = dqir_pkg::DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  dqir_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output dqir_pkg::rsp_t rsp
);

    dqir_pkg::cmd_t cmd;

    dqir_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd)
    );

    dqir_datapath #(
        .DATA_WIDTH (DATA_WIDTH),
        .DEPTH      (DEPTH)
    ) u_datapath (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .req   (req),
        .rsp   (rsp)
    );

endmodule
